### sv/gtrk_pkg.sv
// ----------------------------------------------------------------------------
// gtrk_pkg
// Shared constants, types and the arctangent table of the track heading unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gtrk_pkg;

    localparam int HIST_DEPTH   = 256;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int HIST_W       = 31 + 31 + 48;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CX_W         = 36;
    localparam int CZ_W         = 34;

    localparam logic [CX_W-1:0] CORDIC_GAIN_Q30 = CX_W'(652032874);

    // register indexes of the configuration port
    localparam logic [7:0] REG_ENABLE   = 8'd0;
    localparam logic [7:0] REG_TRACK    = 8'd1;
    localparam logic [7:0] REG_MAX_AGE  = 8'd2;
    localparam logic [7:0] REG_YAW_COV  = 8'd3;

    typedef enum logic {
        CM_VECTOR = 1'b0,
        CM_ROTATE = 1'b1
    } t_cordic_mode;

    typedef struct packed {
        logic                   start;
        t_cordic_mode           mode;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cordic_req;

    typedef struct packed {
        logic                   done;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cordic_rsp;

    // arctangent of 2^-i, 2^31 per pi
    function automatic logic signed [CZ_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

`default_nettype wire

### sv/gtrk_hist_ram.sv
// ----------------------------------------------------------------------------
// gtrk_hist_ram
// Single-port history memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrk_hist_ram #(
    parameter int WIDTH = 110,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### sv/gtrk_cordic.sv
// ----------------------------------------------------------------------------
// gtrk_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrk_cordic (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gtrk_pkg::t_cordic_req i_req,
    output gtrk_pkg::t_cordic_rsp      o_rsp
);
    import gtrk_pkg::*;

    logic signed [CX_W-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [CZ_W-1:0] r_z, n_z, at;
    logic [STEP_W-1:0]      r_i;
    logic                   r_busy, r_done;
    t_cordic_mode           r_mode;
    logic                   dir;

    // one micro-rotation
    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        at  = atan_lut(r_i);
        dir = (r_mode == CM_VECTOR) ? !r_y[CX_W-1] : !r_z[CZ_W-1];
        if (r_mode == CM_VECTOR) begin
            if (dir) begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + at;
            end else begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - at;
            end
        end else begin
            if (dir) begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - at;
            end else begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + at;
            end
        end
    end

    // load on start, iterate while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_x    <= i_req.x;
            r_y    <= i_req.y;
            r_z    <= i_req.z;
            r_mode <= i_req.mode;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;

endmodule

`default_nettype wire

### sv/gnss_track_heading_estimator_unit.sv
// ----------------------------------------------------------------------------
// gnss_track_heading_estimator_unit
// Course-over-ground heading from a ring of past GNSS fixes.
// ----------------------------------------------------------------------------
// Usage: fixes enter on the s_axis channel; tdata packs pos_x, pos_y, stamp_us
// and tuser packs pos_valid, reversing. Each fix yields exactly one result on
// m_axis: tdata packs heading, quat_z, quat_w, yaw_variance, tuser holds the
// inject flag. Registers are written on the cfg channel (always ready); the
// user writes them only while the block is idle, not enforced by the block.
// Flow: a skipped fix goes straight to the result stage. A used fix is pushed
// into the history memory, then the walk back visits one entry at a time
// (address, memory read, difference, two squares, compare), bound by the
// single memory port; up to 256 entries. A hit adds the two passes of the
// shared 28-step CORDIC. One fix is processed at a time.
// Reset clears the ring fill count and loads register defaults; the memory
// itself is not cleared, only written entries are ever visited.
// A stalled receiver holds the result register; the next fix may be accepted
// and processed, finishing only once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module gnss_track_heading_estimator_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // pos_x[30:0], pos_y[61:31], stamp_us[109:62], zero fill
    input  wire logic [111:0] s_axis_tdata,
    // pos_valid[0], reversing[1]
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // heading[15:0], quat_z[31:16], quat_w[47:32], yaw_variance[79:48]
    output logic [79:0]       m_axis_tdata,
    // inject[0]
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import gtrk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_RD, S_RW, S_DIF, S_SQA, S_SQB, S_CMP,
        S_VEC, S_VWAIT, S_ROT, S_RWAIT, S_FIN
    } t_state;

    t_state r_state;

    logic        r_en;
    logic [29:0] r_td;
    logic [31:0] r_age, r_cov;

    logic signed [30:0] r_px, r_py;
    logic [47:0]        r_now;
    logic [59:0]        r_thr;
    logic [HIST_AW-1:0] r_newest, r_addr, slot;
    logic [HIST_AW:0]   r_fill, r_k;
    logic               r_we;
    logic [HIST_W-1:0]  rdata;
    logic signed [31:0] r_dx, r_dy;
    logic [47:0]        r_old;
    logic [63:0]        r_a, r_b;
    logic [64:0]        sum;
    logic [63:0]        d2;
    logic [47:0]        age;
    logic [15:0]        r_h, h_vec;
    logic [31:0]        zsum;
    logic signed [CX_W-1:0] yr, xr;
    logic signed [20:0] sq, cq;

    logic        r_winj;
    logic [15:0] r_wz, r_ww;

    logic        r_oinj;
    logic [15:0] r_oh, r_oz, r_ow;
    logic [31:0] r_ocov;
    logic        r_ovalid;

    t_cordic_req creq;
    t_cordic_rsp crsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ocov, r_ow, r_oz, r_oh};
    assign m_axis_tuser  = r_oinj;

    gtrk_hist_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_addr  (r_addr),
        .i_wdata ({r_now, r_py, r_px}),
        .o_rdata (rdata)
    );

    gtrk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (creq),
        .o_rsp   (crsp)
    );

    // slot of the k-th newest entry
    always_comb begin
        if (r_k[HIST_AW-1:0] <= r_newest && r_k < (HIST_AW+1)'(HIST_DEPTH)) begin
            slot = r_newest - r_k[HIST_AW-1:0];
        end else begin
            slot = HIST_AW'((HIST_AW+1)'(r_newest) + (HIST_AW+1)'(HIST_DEPTH)
                   - r_k);
        end
    end

    // distance, age and rounding arithmetic
    always_comb begin
        sum   = {1'b0, r_a} + {1'b0, r_b};
        d2    = sum[64] ? '1 : sum[63:0];
        age   = (r_now >= r_old) ? r_now - r_old : '0;
        zsum  = crsp.z[31:0] + 32'h8000;
        h_vec = zsum[31:16];
        yr    = crsp.y + CX_W'(16384);
        xr    = crsp.x + CX_W'(16384);
        sq    = 21'(yr >>> 15);
        cq    = 21'(xr >>> 15);
    end

    // cordic requests
    always_comb begin
        creq.start = 1'b0;
        creq.mode  = CM_VECTOR;
        creq.x     = CX_W'(r_dx);
        creq.y     = CX_W'(r_dy);
        creq.z     = '0;
        if (r_state == S_VEC) begin
            creq.start = 1'b1;
            if (r_dx < 0) begin
                if (r_dy >= 0) begin
                    creq.x = CX_W'(r_dy);
                    creq.y = -CX_W'(r_dx);
                    creq.z = CZ_W'(1073741824);
                end else begin
                    creq.x = -CX_W'(r_dy);
                    creq.y = CX_W'(r_dx);
                    creq.z = -CZ_W'(1073741824);
                end
            end
        end else if (r_state == S_ROT) begin
            creq.start = 1'b1;
            creq.mode  = CM_ROTATE;
            creq.x     = CORDIC_GAIN_Q30;
            creq.y     = '0;
            creq.z     = CZ_W'($signed({r_h, 15'b0}));
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b1;
            r_td  <= 30'd32768;
            r_age <= 32'd1000000;
            r_cov <= 32'd13107;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:  r_en  <= i_cfg_data[0];
                REG_TRACK:   r_td  <= i_cfg_data[29:0];
                REG_MAX_AGE: r_age <= i_cfg_data;
                REG_YAW_COV: r_cov <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: push, walk back, heading, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_fill   <= '0;
            r_we     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_we <= (r_state == S_PUSH);
            // load the result register when free, drop it once taken
            if (r_state == S_FIN && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_px   <= $signed(s_axis_tdata[30:0]);
                        r_py   <= $signed(s_axis_tdata[61:31]);
                        r_now  <= s_axis_tdata[109:62];
                        r_thr  <= 60'(r_td * r_td);
                        r_winj <= 1'b0;
                        r_h    <= '0;
                        r_wz   <= '0;
                        r_ww   <= '0;
                        if (r_en && s_axis_tuser[0] && !s_axis_tuser[1]) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_PUSH: begin
                    // advance the ring and write the new fix
                    if (r_newest == HIST_AW'(HIST_DEPTH - 1)) begin
                        r_newest <= '0;
                        r_addr   <= '0;
                    end else begin
                        r_newest <= r_newest + 1'b1;
                        r_addr   <= r_newest + 1'b1;
                    end
                    if (r_fill < (HIST_AW+1)'(HIST_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_k     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_addr  <= slot;
                    r_state <= S_RW;
                end
                // wait for the registered read data
                S_RW: r_state <= S_DIF;
                S_DIF: begin
                    r_dx    <= 32'(r_px) - 32'($signed(rdata[30:0]));
                    r_dy    <= 32'(r_py) - 32'($signed(rdata[61:31]));
                    r_old   <= rdata[109:62];
                    r_state <= S_SQA;
                end
                S_SQA: begin
                    r_a     <= 64'(r_dx * r_dx);
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_b     <= 64'(r_dy * r_dy);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (d2 >= 64'(r_thr)) begin
                        if (age > 48'(r_age)) begin
                            r_state <= S_FIN;
                        end else if (r_dx == 0 && r_dy == 0) begin
                            r_h     <= '0;
                            r_state <= S_ROT;
                        end else begin
                            r_state <= S_VEC;
                        end
                    end else if (r_k + 1'b1 >= r_fill) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_VEC: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (crsp.done) begin
                        r_h     <= h_vec;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (crsp.done) begin
                        r_winj  <= 1'b1;
                        r_wz    <= (sq > 21'sd32767) ? 16'h7FFF :
                                   (sq < -21'sd32768) ? 16'h8000 : sq[15:0];
                        r_ww    <= (cq > 21'sd32767) ? 16'h7FFF :
                                   (cq < -21'sd32768) ? 16'h8000 : cq[15:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hand over once the result register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_oinj  <= r_winj;
                        r_oh    <= r_h;
                        r_oz    <= r_wz;
                        r_ow    <= r_ww;
                        r_ocov  <= r_winj ? r_cov : 32'd0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GNSS track heading unit: a directed table of
// fixes followed by random trajectories and noise over several register settings,
// results checked against a CORDIC-exact heading predictor or typed expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import gtrk_pkg::*;

    localparam int          RING_DEPTH  = 256;
    localparam int          CYCLE_LIMIT = 5_000_000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          HOLD_CYCLES = 3000;
    localparam logic [7:0]  REG_UNUSED  = 8'd4;
    localparam longint      ROT_START   = 64'sd652032874;

    localparam longint ATAN_STEP [28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    typedef struct packed {
        logic               inject;
        logic signed [15:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [31:0]        yaw_var;
    } heading_t;

    typedef struct packed {
        logic signed [30:0] x;
        logic signed [30:0] y;
        logic [47:0]        stamp;
        logic               valid;
        logic               rev;
        logic               typed;
        heading_t           exp;
    } fix_row_t;

    localparam heading_t NO_HEADING = '0;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [111:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    // predictor copy of registers and history ring
    logic         en_q = 1'b1;
    logic [29:0]  track_q = 30'd32768;
    logic [31:0]  age_q = 32'd1000000;
    logic [31:0]  cov_q = 32'd13107;
    longint       ring_x [RING_DEPTH];
    longint       ring_y [RING_DEPTH];
    logic [47:0]  ring_stamp [RING_DEPTH];
    int           ring_head = 0;
    int           ring_fill = 0;

    heading_t     heading_q [$];
    int           mismatches = 0;
    int           fixes_accepted = 0;
    bit           quiet = 1'b0;
    int           cycles = 0;

    gnss_track_heading_estimator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // angle of (x, y), 2^31 per pi, wrapped to 32 bits
    function automatic logic [31:0] vector_angle(input longint x, input longint y);
        longint z, t, xs, ys;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 64'sd1073741824;
            end else begin
                x = -y; y = t; z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < 28; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_STEP[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_STEP[i];
            end
        end
        return z[31:0];
    endfunction

    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // one accepted fix: update the ring and work out the heading result
    function automatic heading_t track_heading(input fix_row_t f);
        heading_t   res;
        longint     px, py, dx, dy, x, y, z, xs, ys;
        logic [63:0] thresh, sq_a, sq_b, d2, age;
        logic [31:0] ang;
        logic [15:0] h;
        int         slot;
        res = NO_HEADING;
        px = longint'(f.x);
        py = longint'(f.y);
        if (!en_q || f.rev || !f.valid) return res;
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_x[ring_head] = px;
        ring_y[ring_head] = py;
        ring_stamp[ring_head] = f.stamp;
        if (ring_fill < RING_DEPTH) ring_fill++;
        thresh = 64'(track_q) * 64'(track_q);
        for (int k = 0; k < ring_fill; k++) begin
            slot = (ring_head + RING_DEPTH - k) % RING_DEPTH;
            dx = px - ring_x[slot];
            dy = py - ring_y[slot];
            sq_a = dx * dx;
            sq_b = dy * dy;
            d2 = sq_a + sq_b;
            if (d2 < sq_a) d2 = '1;
            if (d2 >= thresh) begin
                age = (f.stamp >= ring_stamp[slot]) ? 64'(f.stamp - ring_stamp[slot]) : 64'd0;
                if (age > 64'(age_q)) return res;
                if (dx == 0 && dy == 0) begin
                    h = '0;
                end else begin
                    ang = vector_angle(dx, dy) + 32'h8000;
                    h = ang[31:16];
                end
                // rotate the gain-compensated unit vector by half the heading
                x = ROT_START;
                y = 0;
                z = longint'($signed(h)) * 32768;
                for (int i = 0; i < 28; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z >= 0) begin
                        x -= ys; y += xs; z -= ATAN_STEP[i];
                    end else begin
                        x += ys; y -= xs; z += ATAN_STEP[i];
                    end
                end
                res.inject = 1'b1;
                res.heading = h;
                res.quat_z = round_q15(y);
                res.quat_w = round_q15(x);
                res.yaw_var = cov_q;
                return res;
            end
        end
        return res;
    endfunction

    // offer one fix with an optional gap, hold until accepted
    task automatic send_fix(input fix_row_t f);
        heading_t pred;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tdata  <= {2'b00, f.stamp, f.y, f.x};
        s_axis_tuser  <= {f.rev, f.valid};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = track_heading(f);
        heading_q.insert(heading_q.size(), f.typed ? f.exp : pred);
        fixes_accepted++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ENABLE:  en_q = val[0];
            REG_TRACK:   track_q = val[29:0];
            REG_MAX_AGE: age_q = val;
            REG_YAW_COV: cov_q = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // receiver: short random stalls, one long hold-off to back up the block
    initial begin : rx_ready
        int  burst;
        bit  held;
        burst = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && fixes_accepted >= 100) begin
                held = 1'b1;
                burst = HOLD_CYCLES;
            end
            if (burst > 0) begin
                m_axis_tready <= 1'b0;
                burst--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        heading_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[47:32], m_axis_tdata[79:48]};
            if (heading_q.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                mismatches++;
            end else begin
                want = heading_q[0];
                heading_q.delete(0);
                if (got.inject !== want.inject) begin
                    $display("%0t: inject exp %0d got %0d", $time, want.inject, got.inject);
                    mismatches++;
                end
                if (got.heading !== want.heading) begin
                    $display("%0t: heading exp %0d got %0d", $time, want.heading, got.heading);
                    mismatches++;
                end
                if (got.quat_z !== want.quat_z) begin
                    $display("%0t: quat_z exp %0d got %0d", $time, want.quat_z, got.quat_z);
                    mismatches++;
                end
                if (got.quat_w !== want.quat_w) begin
                    $display("%0t: quat_w exp %0d got %0d", $time, want.quat_w, got.quat_w);
                    mismatches++;
                end
                if (got.yaw_var !== want.yaw_var) begin
                    $display("%0t: yaw_variance exp %0d got %0d", $time, want.yaw_var,
                             got.yaw_var);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL gnss_track_heading_estimator_unit");
            $finish;
        end
    end

    initial begin : stimulus
        fix_row_t    dir_rows [$];
        fix_row_t    f;
        longint      cx, cy;
        logic [47:0] now;
        logic [31:0] pick;

        // straight moves, the west move wraps to -pi; typed rows are no-result cases
        dir_rows = '{
            '{31'sd0, 31'sd0, 48'd0, 1'b1, 1'b0, 1'b1, NO_HEADING},
            '{31'sd5, 31'sd5, 48'd10, 1'b0, 1'b0, 1'b1, NO_HEADING},
            '{31'sd9, 31'sd9, 48'd20, 1'b1, 1'b1, 1'b1, NO_HEADING},
            '{31'sd65536, 31'sd0, 48'd1000, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd65536, 31'sd65536, 48'd2000, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd0, 31'sd65536, 48'd3000, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd0, 31'sd0, 48'd4000, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd100, 31'sd50, 48'd5000, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd70000, 31'sd30000, 48'd6000, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd140000, 31'sd30000, 48'd2006001, 1'b1, 1'b0, 1'b1, NO_HEADING},
            '{31'sd1073741823, 31'sd1073741823, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0,
              NO_HEADING},
            '{-31'sd1073741824, -31'sd1073741824, 48'd0, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{-31'sd1073741824, 31'sd1073741823, 48'd5, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd1073741823, -31'sd1073741824, 48'd7, 1'b1, 1'b0, 1'b0, NO_HEADING},
            '{31'sd3, 31'sd3, 48'd9, 1'b0, 1'b1, 1'b1, NO_HEADING}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset register values
        foreach (dir_rows[i]) send_fix(dir_rows[i]);
        wait_idle();

        // an unused index must not disturb anything
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);

        cx = 0;
        cy = 0;
        now = 48'd100000;
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            quiet = (phase == 5);
            pick = $urandom_range(0, 3);
            case (phase)
                0: write_reg(REG_TRACK, 32'd0);
                1: write_reg(REG_TRACK, 32'hFFFF_FFFF);
                default: write_reg(REG_TRACK, (pick == 0) ? 32'd32768 : $urandom_range(1, 400000));
            endcase
            case (phase)
                2: write_reg(REG_MAX_AGE, 32'd0);
                3: write_reg(REG_MAX_AGE, 32'hFFFF_FFFF);
                default: write_reg(REG_MAX_AGE, $urandom_range(200000, 3000000));
            endcase
            case (phase)
                1: write_reg(REG_YAW_COV, 32'd0);
                2: write_reg(REG_YAW_COV, 32'hFFFF_FFFF);
                default: write_reg(REG_YAW_COV, $urandom);
            endcase
            write_reg(REG_ENABLE, (phase == 4) ? 32'hFFFF_FFFE : 32'h0000_0001);
            if (phase == 4) begin
                // disabled: a few fixes, then enable again
                for (int n = 0; n < 8; n++) begin
                    f = '{31'($urandom), 31'($urandom), 48'({$urandom, $urandom}), 1'b1,
                          1'b0, 1'b1, NO_HEADING};
                    send_fix(f);
                end
                wait_idle();
                write_reg(REG_ENABLE, 32'd1);
            end
            for (int n = 0; n < 62; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    // noise: full-range fields and random flags
                    f.x = 31'($urandom);
                    f.y = 31'($urandom);
                    f.stamp = 48'({$urandom, $urandom});
                    f.valid = 1'($urandom);
                    f.rev = 1'($urandom);
                end else begin
                    // well-formed trajectory step
                    cx += $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
                    cy += $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
                    if (cx > 1000000000 || cx < -1000000000) cx = 0;
                    if (cy > 1000000000 || cy < -1000000000) cy = 0;
                    now += 48'($urandom_range(0, 300000));
                    f.x = cx[30:0];
                    f.y = cy[30:0];
                    f.stamp = now;
                    f.valid = ($urandom_range(0, 15) != 0);
                    f.rev = ($urandom_range(0, 15) == 0);
                end
                f.typed = 1'b0;
                f.exp = NO_HEADING;
                send_fix(f);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS gnss_track_heading_estimator_unit");
        end else begin
            $display("FAIL gnss_track_heading_estimator_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
